[sv/grsm_pkg.sv]
// ---------------------------------------------------------------------------
// grsm_pkg : shared types and constants of the Golomb-Rice set matcher
// Widths, operation codes, register indexes and the command beat carried
// from the front queue to the decode engine.
// ---------------------------------------------------------------------------
package grsm_pkg;

   // field widths
   localparam int HASH_W   = 64;
   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 32;
   localparam int RICE_W   = 6;
   localparam int OP_W     = 2;

   // query table sizing (up to 16 queries)
   localparam int MAX_QUERIES = 16;
   localparam int QCNT_W      = $clog2(MAX_QUERIES + 1);
   localparam int QIDX_W      = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;

   // command queue between front and back, depth must be a power of two
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // bit-serial walk over one filter byte
   localparam int BITCNT_W = $clog2(BYTE_W + 1);

   // configuration registers
   localparam int                REG_IDX_W         = 1;
   localparam logic [REG_IDX_W-1:0] REG_RICE_BITS     = 1'd0;
   localparam logic [REG_IDX_W-1:0] REG_ELEMENT_COUNT = 1'd1;
   localparam logic [RICE_W-1:0]    RICE_RESET        = 6'd19;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_BYTE  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // one classified command beat
   typedef struct packed {
      op_type              op;
      logic [HASH_W-1:0]   query_hash;
      logic [BYTE_W-1:0]   filter_byte;
   } cmd_type;

endpackage

[sv/grsm_front.sv]
// ---------------------------------------------------------------------------
// grsm_front : input side of the set matcher
// Accepts request beats, classifies the operation code and holds them in a
// short queue so that the decode engine can stall on its own.
// ---------------------------------------------------------------------------
module grsm_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [grsm_pkg::OP_W-1:0]    req_operation,
   input  logic [grsm_pkg::HASH_W-1:0]  req_query_hash,
   input  logic [grsm_pkg::BYTE_W-1:0]  req_filter_byte,
   output logic                         cmd_valid,
   output grsm_pkg::cmd_type            cmd,
   input  logic                         cmd_take
);
   import grsm_pkg::*;

   cmd_type                entry_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]  count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;
   cmd_type                new_cmd;

   // classify the incoming beat
   always_comb begin
      new_cmd.op          = op_type'(req_operation);
      new_cmd.query_hash  = req_query_hash;
      new_cmd.filter_byte = req_filter_byte;
   end

   assign full      = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   // pointers wrap naturally, depth is a power of two
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, payload only
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   // queue bookkeeping checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CMDQ_CNT_W'(CMDQ_DEPTH))
      else $error("command queue count above depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push without count step");

endmodule

[sv/grsm_back.sv]
// ---------------------------------------------------------------------------
// grsm_back : decode engine of the set matcher
// Walks filter bytes one bit a cycle through the Golomb-Rice decoder, pausing
// to add each delta to the running value and merge it against the query table,
// one query per cycle. Holds the result register seen on the output side.
// ---------------------------------------------------------------------------
module grsm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  grsm_pkg::cmd_type             cmd,
   output logic                          cmd_take,
   input  logic [grsm_pkg::RICE_W-1:0]   rice_bits,
   input  logic [grsm_pkg::COUNT_W-1:0]  element_count,
   output logic                          empty,
   input  logic                          pop,
   output logic                          rsp_decided,
   output logic                          rsp_matched,
   output logic [grsm_pkg::COUNT_W-1:0]  rsp_values_decoded
);
   import grsm_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_BIT    = 5'b00010,
      S_FINISH = 5'b00100,
      S_MERGE  = 5'b01000,
      S_RESULT = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [HASH_W-1:0]       qtab_ff [MAX_QUERIES];
   logic                    qtab_we;
   logic [QCNT_W-1:0]       qcnt_ff, qcnt_in;
   logic [QCNT_W-1:0]       qpos_ff, qpos_in;
   logic [HASH_W-1:0]       unary_ff, unary_in;
   logic [HASH_W-1:0]       racc_ff, racc_in;
   logic [RICE_W-1:0]       seen_ff, seen_in;
   logic                    in_rem_ff, in_rem_in;
   logic [HASH_W-1:0]       run_ff, run_in;
   logic [COUNT_W-1:0]      total_ff, total_in;
   logic                    final_ff, final_in;
   logic                    match_ff, match_in;
   logic [BYTE_W-1:0]       shreg_ff, shreg_in;
   logic [BITCNT_W-1:0]     taken_ff, taken_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_decided_ff, rsp_decided_in;
   logic                    rsp_matched_ff, rsp_matched_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                    exhausted;
   logic                    cur_bit;
   logic                    go_finish;
   logic [HASH_W-1:0]       qhead;

   assign empty              = !rsp_valid_ff;
   assign rsp_decided        = rsp_decided_ff;
   assign rsp_matched        = rsp_matched_ff;
   assign rsp_values_decoded = rsp_count_ff;

   assign exhausted = !final_ff && (total_ff >= element_count);
   assign cur_bit   = shreg_ff[BYTE_W-1];
   assign qhead     = qtab_ff[qpos_ff[QIDX_W-1:0]];

   // engine sequencing
   always_comb begin
      state_in       = state_ff;
      qcnt_in        = qcnt_ff;
      qpos_in        = qpos_ff;
      unary_in       = unary_ff;
      racc_in        = racc_ff;
      seen_in        = seen_ff;
      in_rem_in      = in_rem_ff;
      run_in         = run_ff;
      total_in       = total_ff;
      final_in       = final_ff;
      match_in       = match_ff;
      shreg_in       = shreg_ff;
      taken_in       = taken_ff;
      rsp_valid_in   = rsp_valid_ff && !pop;
      rsp_decided_in = rsp_decided_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_count_in   = rsp_count_ff;
      cmd_take       = 1'b0;
      qtab_we        = 1'b0;
      go_finish      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            // start only once the result slot will be free
            if (cmd_valid && (!rsp_valid_ff || pop)) begin
               cmd_take = 1'b1;
               state_in = S_RESULT;
               unique case (cmd.op)
                  OP_LOAD: begin
                     if (qcnt_ff < QCNT_W'(MAX_QUERIES)) begin
                        qtab_we = 1'b1;
                        qcnt_in = qcnt_ff + 1'b1;
                     end
                  end
                  OP_BYTE: begin
                     shreg_in = cmd.filter_byte;
                     taken_in = '0;
                     state_in = S_BIT;
                  end
                  OP_CLEAR: begin
                     qcnt_in   = '0;
                     qpos_in   = '0;
                     unary_in  = '0;
                     racc_in   = '0;
                     seen_in   = '0;
                     in_rem_in = 1'b0;
                     run_in    = '0;
                     total_in  = '0;
                     final_in  = 1'b0;
                     match_in  = 1'b0;
                  end
                  OP_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_BIT: begin
            if (final_ff || exhausted) begin
               // answer final: rest of the byte is dropped
               if (exhausted) begin
                  final_in = 1'b1;
                  match_in = 1'b0;
               end
               state_in = S_RESULT;
            end else begin
               shreg_in = {shreg_ff[BYTE_W-2:0], 1'b0};
               taken_in = taken_ff + 1'b1;
               if (!in_rem_ff) begin
                  if (cur_bit) begin
                     unary_in = unary_ff + 1'b1;
                  end else begin
                     in_rem_in = 1'b1;
                     racc_in   = '0;
                     seen_in   = '0;
                     go_finish = (rice_bits == '0);
                  end
               end else begin
                  racc_in   = {racc_ff[HASH_W-2:0], cur_bit};
                  seen_in   = seen_ff + 1'b1;
                  go_finish = (({1'b0, seen_ff} + 1'b1) >= {1'b0, rice_bits});
               end
               if (go_finish) begin
                  state_in = S_FINISH;
               end else if (taken_ff == BITCNT_W'(BYTE_W - 1)) begin
                  state_in = S_RESULT;
               end
            end
         end

         S_FINISH: begin
            // remainder fits below the shifted quotient, so OR joins them
            run_in    = run_ff + ((unary_ff << rice_bits) | racc_ff);
            total_in  = total_ff + 1'b1;
            unary_in  = '0;
            racc_in   = '0;
            seen_in   = '0;
            in_rem_in = 1'b0;
            state_in  = S_MERGE;
         end

         S_MERGE: begin
            // one query compared per cycle
            if (qpos_ff < qcnt_ff) begin
               if (qhead == run_ff) begin
                  final_in = 1'b1;
                  match_in = 1'b1;
                  state_in = S_RESULT;
               end else if (qhead > run_ff) begin
                  state_in = (taken_ff == BITCNT_W'(BYTE_W)) ? S_RESULT : S_BIT;
               end else begin
                  qpos_in = qpos_ff + 1'b1;
               end
            end else begin
               final_in = 1'b1;
               match_in = 1'b0;
               state_in = S_RESULT;
            end
         end

         S_RESULT: begin
            if (exhausted) begin
               final_in = 1'b1;
               match_in = 1'b0;
            end
            rsp_valid_in   = 1'b1;
            rsp_decided_in = final_ff || exhausted;
            rsp_matched_in = final_ff && match_ff && !exhausted;
            rsp_count_in   = total_ff;
            state_in       = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         qcnt_ff      <= '0;
         qpos_ff      <= '0;
         unary_ff     <= '0;
         racc_ff      <= '0;
         seen_ff      <= '0;
         in_rem_ff    <= 1'b0;
         run_ff       <= '0;
         total_ff     <= '0;
         final_ff     <= 1'b0;
         match_ff     <= 1'b0;
         taken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         qcnt_ff      <= qcnt_in;
         qpos_ff      <= qpos_in;
         unary_ff     <= unary_in;
         racc_ff      <= racc_in;
         seen_ff      <= seen_in;
         in_rem_ff    <= in_rem_in;
         run_ff       <= run_in;
         total_ff     <= total_in;
         final_ff     <= final_in;
         match_ff     <= match_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: byte shifter, result beat and query table
   always_ff @(posedge clock) begin
      shreg_ff       <= shreg_in;
      rsp_decided_ff <= rsp_decided_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_count_ff   <= rsp_count_in;
      if (qtab_we) begin
         qtab_ff[qcnt_ff[QIDX_W-1:0]] <= cmd.query_hash;
      end
   end

   // engine checks
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT) |-> !rsp_valid_ff)
      else $error("result slot overwritten");

   a_qpos_bound: assert property (@(posedge clock) disable iff (reset)
      (qpos_ff <= qcnt_ff) && (qcnt_ff <= QCNT_W'(MAX_QUERIES)))
      else $error("query pointer beyond loaded queries");

   a_bits_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BIT) |-> (taken_ff <= BITCNT_W'(BYTE_W)))
      else $error("bit walk ran past the byte");

   a_match_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_matched_ff || rsp_decided_ff))
      else $error("match reported before answer is final");

endmodule

[sv/golomb_rice_set_matcher_top.sv]
// ---------------------------------------------------------------------------
// golomb_rice_set_matcher_top : Golomb-Rice coded set membership matcher
// Loads sorted query hashes, decodes a Golomb-Rice coded set stream and
// reports whether any query hits a decoded value. Holds the registers.
//
//   channel   handshake           payload
//   request   push / full         req_operation, req_query_hash, req_filter_byte
//   result    empty / pop         rsp_decided, rsp_matched, rsp_values_decoded
//   config    csr_we              csr_index, csr_wdata
//
// Load, clear and idle beats pass from the idle state to the result state. A filter
// byte is walked bit by bit in the bit state; each value it completes passes an add
// state and a compare state that steps past one query at a time, and stopping in the
// bit walk on a final answer or a run-out value count takes a last visit to the bit state.
// One beat at a time in the engine; a 4-beat queue in front keeps accepting
// while it is busy or the result waits for pop. Synchronous active-high reset.
// ---------------------------------------------------------------------------
module golomb_rice_set_matcher_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [grsm_pkg::OP_W-1:0]         req_operation,
   input  logic [grsm_pkg::HASH_W-1:0]       req_query_hash,
   input  logic [grsm_pkg::BYTE_W-1:0]       req_filter_byte,
   output logic                              empty,
   input  logic                              pop,
   output logic                              rsp_decided,
   output logic                              rsp_matched,
   output logic [grsm_pkg::COUNT_W-1:0]      rsp_values_decoded,
   input  logic                              csr_we,
   input  logic [grsm_pkg::REG_IDX_W-1:0]    csr_index,
   input  logic [grsm_pkg::COUNT_W-1:0]      csr_wdata
);
   import grsm_pkg::*;

   logic [RICE_W-1:0]   rice_bits_ff, rice_bits_in;
   logic [COUNT_W-1:0]  element_count_ff, element_count_in;
   logic                cmd_valid;
   logic                cmd_take;
   cmd_type             cmd;

   // configuration registers
   always_comb begin
      rice_bits_in     = rice_bits_ff;
      element_count_in = element_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_RICE_BITS:     rice_bits_in     = csr_wdata[RICE_W-1:0];
            REG_ELEMENT_COUNT: element_count_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rice_bits_ff     <= RICE_RESET;
         element_count_ff <= '0;
      end else begin
         rice_bits_ff     <= rice_bits_in;
         element_count_ff <= element_count_in;
      end
   end

   // request side
   grsm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_operation   (req_operation),
      .req_query_hash  (req_query_hash),
      .req_filter_byte (req_filter_byte),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_take        (cmd_take)
   );

   // decode and merge engine
   grsm_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_take           (cmd_take),
      .rice_bits          (rice_bits_ff),
      .element_count      (element_count_ff),
      .empty              (empty),
      .pop                (pop),
      .rsp_decided        (rsp_decided),
      .rsp_matched        (rsp_matched),
      .rsp_values_decoded (rsp_values_decoded)
   );

endmodule
